// File: rtl/ecfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecfp_pkg - shared types and constants of the escaped CRC frame parser
// Token passed from the parse front to the execute back, codes and the CRC step.
// ----------------------------------------------------------------------------
package ecfp_pkg;

	localparam logic [7:0]  SYNC_BYTE = 8'h7E;
	localparam logic [7:0]  ESC_BYTE  = 8'h1B;
	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [15:0] CRC_SEED  = 16'h7E7E;

	typedef enum logic [2:0] {
		PH_SYNC1,
		PH_SYNC2,
		PH_HEADER,
		PH_PAYLOAD,
		PH_CRCLO,
		PH_CRCHI,
		PH_DONE
	} phase_t;

	// work the back end does for one word
	typedef enum logic [2:0] {
		OP_NOP,
		OP_ESC,
		OP_HDR,
		OP_PAY,
		OP_CRCLO,
		OP_CRCHI,
		OP_SYNC_ERR,
		OP_TRUNC
	} op_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD,
		KIND_ACCEPT,
		KIND_REJECT
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_SYNC,
		ERR_TRUNC,
		ERR_CRC
	} err_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic [7:0] idx;
		logic       last;   // end of buffer: back end state returns to reset
	} token_t;

	// CRC-16, polynomial 0x1021, message bits shifted in MSB first
	function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] d);
		logic [15:0] c;
		logic        top;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			top = c[15];
			c = {c[14:0], d[i]};
			if (top)
				c = c ^ CRC_POLY;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// File: rtl/ecfp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecfp_front - byte classifier
// Tracks sync, escape and field position of each received byte and turns it
// into a token for the back end.
// ----------------------------------------------------------------------------
module ecfp_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [7:0]       rx_byte,
	input  wire logic             end_of_buffer,
	output ecfp_pkg::token_t      token,
	output logic                  token_valid
);

	ecfp_pkg::phase_t phase_q, phase_d;
	logic             esc_q, esc_d;
	logic [7:0]       fcnt_q, fcnt_d;
	logic [7:0]       len_q, len_d;
	logic             is_esc;

	assign is_esc = !esc_q && (rx_byte == ecfp_pkg::ESC_BYTE);

	always_comb begin
		phase_d     = phase_q;
		esc_d       = esc_q;
		fcnt_d      = fcnt_q;
		len_d       = len_q;
		token.op    = ecfp_pkg::OP_NOP;
		token.data  = rx_byte;
		token.idx   = fcnt_q;
		token.last  = end_of_buffer;
		unique case (phase_q)
			ecfp_pkg::PH_SYNC1, ecfp_pkg::PH_SYNC2: begin
				if (rx_byte != ecfp_pkg::SYNC_BYTE) begin
					token.op = ecfp_pkg::OP_SYNC_ERR;
					phase_d  = ecfp_pkg::PH_DONE;
				end else if (phase_q == ecfp_pkg::PH_SYNC1) begin
					phase_d = ecfp_pkg::PH_SYNC2;
				end else begin
					phase_d = ecfp_pkg::PH_HEADER;
				end
			end
			ecfp_pkg::PH_HEADER: begin
				if (is_esc) begin
					token.op = ecfp_pkg::OP_ESC;
					esc_d    = 1'b1;
				end else begin
					token.op = ecfp_pkg::OP_HDR;
					esc_d    = 1'b0;
					if (fcnt_q == 8'd3) begin
						len_d   = rx_byte;
						fcnt_d  = '0;
						phase_d = (rx_byte == 8'd0) ? ecfp_pkg::PH_CRCLO : ecfp_pkg::PH_PAYLOAD;
					end else begin
						fcnt_d = fcnt_q + 8'd1;
					end
				end
			end
			ecfp_pkg::PH_PAYLOAD: begin
				if (is_esc) begin
					token.op = ecfp_pkg::OP_ESC;
					esc_d    = 1'b1;
				end else begin
					token.op = ecfp_pkg::OP_PAY;
					esc_d    = 1'b0;
					// index stays below the length, so the increment cannot wrap
					if (fcnt_q + 8'd1 >= len_q) begin
						fcnt_d  = '0;
						phase_d = ecfp_pkg::PH_CRCLO;
					end else begin
						fcnt_d = fcnt_q + 8'd1;
					end
				end
			end
			ecfp_pkg::PH_CRCLO, ecfp_pkg::PH_CRCHI: begin
				// escape byte in the CRC field is not part of the CRC
				if (is_esc) begin
					esc_d = 1'b1;
				end else begin
					esc_d = 1'b0;
					if (phase_q == ecfp_pkg::PH_CRCLO) begin
						token.op = ecfp_pkg::OP_CRCLO;
						phase_d  = ecfp_pkg::PH_CRCHI;
					end else begin
						token.op = ecfp_pkg::OP_CRCHI;
						phase_d  = ecfp_pkg::PH_DONE;
					end
				end
			end
			default: begin
			end
		endcase
		if (end_of_buffer) begin
			if (phase_d != ecfp_pkg::PH_DONE)
				token.op = ecfp_pkg::OP_TRUNC;
			phase_d = ecfp_pkg::PH_SYNC1;
			esc_d   = 1'b0;
			fcnt_d  = '0;
			len_d   = '0;
		end
	end

	assign token_valid = (token.op != ecfp_pkg::OP_NOP) || end_of_buffer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ecfp_pkg::PH_SYNC1;
			esc_q   <= 1'b0;
			fcnt_q  <= '0;
			len_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			esc_q   <= esc_d;
			fcnt_q  <= fcnt_d;
			len_q   <= len_d;
		end
	end

	a_eob_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_buffer |=> phase_q == ecfp_pkg::PH_SYNC1 && !esc_q)
		else $error("front did not restart after end of buffer");

	a_esc_phase: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> phase_q == ecfp_pkg::PH_HEADER || phase_q == ecfp_pkg::PH_PAYLOAD ||
			phase_q == ecfp_pkg::PH_CRCLO || phase_q == ecfp_pkg::PH_CRCHI)
		else $error("escape pending outside an escaped field");

endmodule
`default_nettype wire

// File: rtl/ecfp_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecfp_fifo - token queue
// Small register queue between the front and the back end.
// ----------------------------------------------------------------------------
module ecfp_fifo #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  full,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + CW'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - CW'(1);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");

endmodule
`default_nettype wire

// File: rtl/ecfp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecfp_back - token executor
// Runs the CRC, keeps the header and builds results into the output register.
// ----------------------------------------------------------------------------
module ecfp_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ecfp_pkg::token_t token,
	input  wire logic             token_avail,
	output logic                  token_take,
	input  wire logic             pop,
	output logic                  empty,
	output logic [1:0]            kind,
	output logic [1:0]            error_code,
	output logic [7:0]            payload_byte,
	output logic [7:0]            payload_index,
	output logic [7:0]            dest_addr,
	output logic [7:0]            src_addr,
	output logic [7:0]            status_byte,
	output logic [7:0]            payload_len
);

	logic [15:0] crc_q;
	logic [7:0]  dest_q, src_q, stat_q, len_q, crclo_q;
	logic        out_valid_q;
	logic        res_valid;
	logic        crc_good;
	ecfp_pkg::kind_t res_kind;
	ecfp_pkg::err_t  res_err;

	assign empty      = !out_valid_q;
	assign token_take = token_avail && (!out_valid_q || pop);
	assign crc_good   = (crclo_q == crc_q[7:0]) && (token.data == crc_q[15:8]);

	always_comb begin
		res_valid = 1'b1;
		res_kind  = ecfp_pkg::KIND_REJECT;
		res_err   = ecfp_pkg::ERR_NONE;
		unique case (token.op)
			ecfp_pkg::OP_PAY:      res_kind = ecfp_pkg::KIND_PAYLOAD;
			ecfp_pkg::OP_SYNC_ERR: res_err  = ecfp_pkg::ERR_SYNC;
			ecfp_pkg::OP_TRUNC:    res_err  = ecfp_pkg::ERR_TRUNC;
			ecfp_pkg::OP_CRCHI: begin
				res_kind = crc_good ? ecfp_pkg::KIND_ACCEPT : ecfp_pkg::KIND_REJECT;
				res_err  = crc_good ? ecfp_pkg::ERR_NONE : ecfp_pkg::ERR_CRC;
			end
			default:               res_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			crc_q       <= ecfp_pkg::CRC_SEED;
			dest_q      <= '0;
			src_q       <= '0;
			stat_q      <= '0;
			len_q       <= '0;
			crclo_q     <= '0;
		end else begin
			if (token_take)
				out_valid_q <= res_valid;
			else if (pop)
				out_valid_q <= 1'b0;
			if (token_take) begin
				if (token.last) begin
					crc_q   <= ecfp_pkg::CRC_SEED;
					dest_q  <= '0;
					src_q   <= '0;
					stat_q  <= '0;
					len_q   <= '0;
					crclo_q <= '0;
				end else begin
					if (token.op == ecfp_pkg::OP_ESC || token.op == ecfp_pkg::OP_HDR ||
							token.op == ecfp_pkg::OP_PAY)
						crc_q <= ecfp_pkg::crc16_next(crc_q, token.data);
					if (token.op == ecfp_pkg::OP_HDR) begin
						unique case (token.idx[1:0])
							2'd0:    dest_q <= token.data;
							2'd1:    src_q  <= token.data;
							2'd2:    stat_q <= token.data;
							default: len_q  <= token.data;
						endcase
					end
					if (token.op == ecfp_pkg::OP_CRCLO)
						crclo_q <= token.data;
				end
			end
		end
	end

	// result word; header fields only with an accepted frame
	always_ff @(posedge clk) begin
		if (token_take && res_valid) begin
			kind          <= res_kind;
			error_code    <= res_err;
			payload_byte  <= (res_kind == ecfp_pkg::KIND_PAYLOAD) ? token.data : 8'd0;
			payload_index <= (res_kind == ecfp_pkg::KIND_PAYLOAD) ? token.idx : 8'd0;
			dest_addr     <= (res_kind == ecfp_pkg::KIND_ACCEPT) ? dest_q : 8'd0;
			src_addr      <= (res_kind == ecfp_pkg::KIND_ACCEPT) ? src_q : 8'd0;
			status_byte   <= (res_kind == ecfp_pkg::KIND_ACCEPT) ? stat_q : 8'd0;
			payload_len   <= (res_kind == ecfp_pkg::KIND_ACCEPT) ? len_q : 8'd0;
		end
	end

	a_reject_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind == ecfp_pkg::KIND_REJECT |-> error_code != ecfp_pkg::ERR_NONE)
		else $error("rejected frame without error code");

	a_good_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind != ecfp_pkg::KIND_REJECT |-> error_code == ecfp_pkg::ERR_NONE)
		else $error("error code on a non-reject word");

endmodule
`default_nettype wire

// File: rtl/escaped_crc_frame_parser_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// escaped_crc_frame_parser_top - byte-stuffed frame deframer with CRC-16 check
// Accepts one received byte per clock while full is low and delivers payload words and a verdict.
// ----------------------------------------------------------------------------
// Takes one raw byte per clock while full is low. A front stage tracks sync,
// escapes and field position and hands a token per byte into a token queue of
// QUEUE_DEPTH entries; the back end runs the CRC-16 (one byte per clock while
// pop keeps up) and loads the output register, so a result is on the result
// ports once its token has passed the queue and the output register, and can
// be popped from there. The sustained rate is one byte per clock while pop
// keeps up; full rises once the queue holds QUEUE_DEPTH tokens behind an
// unread result. Escape bytes inside the CRC field and bytes after a verdict
// make no token unless they end the buffer.
// ----------------------------------------------------------------------------
module escaped_crc_frame_parser_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] rx_byte,
	input  wire logic       end_of_buffer,
	output logic            empty,
	input  wire logic       pop,
	output logic [1:0]      kind,
	output logic [1:0]      error_code,
	output logic [7:0]      payload_byte,
	output logic [7:0]      payload_index,
	output logic [7:0]      dest_addr,
	output logic [7:0]      src_addr,
	output logic [7:0]      status_byte,
	output logic [7:0]      payload_len
);

	localparam int TW = $bits(ecfp_pkg::token_t);

	ecfp_pkg::token_t front_tok, back_tok;
	logic             front_tok_valid;
	logic             accept;
	logic             q_empty;
	logic             take;
	logic [TW-1:0]    q_rd_data;

	assign accept   = push && !full;
	assign back_tok = ecfp_pkg::token_t'(q_rd_data);

	ecfp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.rx_byte       (rx_byte),
		.end_of_buffer (end_of_buffer),
		.token         (front_tok),
		.token_valid   (front_tok_valid)
	);

	ecfp_fifo #(
		.WIDTH (TW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && front_tok_valid),
		.wr_data (front_tok),
		.rd_en   (take),
		.rd_data (q_rd_data),
		.full    (full),
		.empty   (q_empty)
	);

	ecfp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.token         (back_tok),
		.token_avail   (!q_empty),
		.token_take    (take),
		.pop           (pop),
		.empty         (empty),
		.kind          (kind),
		.error_code    (error_code),
		.payload_byte  (payload_byte),
		.payload_index (payload_index),
		.dest_addr     (dest_addr),
		.src_addr      (src_addr),
		.status_byte   (status_byte),
		.payload_len   (payload_len)
	);

endmodule
`default_nettype wire
